FILE: rtl/core/netstring_header_checker_defines.svh
// Assertion macros for the netstring header checker port checks in nshc_checker.sv.
// No dependencies; include by bare file name.
`ifndef NETSTRING_HEADER_CHECKER_DEFINES_SVH
`define NETSTRING_HEADER_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define NSHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nshc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define NSHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nshc: next-cycle check failed");

`endif

FILE: rtl/core/nshc_pkg.sv
// Package for the netstring header checker: types, codes and constants.
// No dependencies.
package nshc_pkg;

	localparam int unsigned HeaderWindowDef = 32;

	// parse phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_NOCOLON  = 3'd2;
	localparam logic [2:0] ST_BADDIGIT = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;
	localparam logic [2:0] ST_EXCEEDS  = 3'd6;
	localparam logic [2:0] ST_NOCOMMA  = 3'd7;

	localparam logic [7:0] Ch0      = 8'h30;
	localparam logic [7:0] Ch9      = 8'h39;
	localparam logic [7:0] ChColon  = 8'h3A;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [31:0] MinFrame = 32'd3;

	typedef struct packed {
		logic [1:0]  phase;
		logic [31:0] byte_index;
		logic [63:0] length_accum;
		logic        overflow_seen;
		logic        bad_digit_seen;
		logic [31:0] latched_buffer_length;
		logic [31:0] comma_position;
		logic [5:0]  colon_position;
	} state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] payload_length;
		logic [5:0]  payload_offset;
	} result_t;

endpackage

FILE: rtl/core/nshc_in_if.sv
// Input channel: one buffer byte per item, with frame start and buffer length.
// Depends on nothing.
interface nshc_in_if ();
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        frame_start;
	logic [31:0] buffer_length;

	modport source (output valid, output data_byte, output frame_start,
		output buffer_length, input ready);
	modport sink (input valid, input data_byte, input frame_start,
		input buffer_length, output ready);
endinterface

FILE: rtl/core/nshc_out_if.sv
// Result channel: one status item per frame.
// Depends on nothing.
interface nshc_out_if ();
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] payload_length;
	logic [5:0]  payload_offset;

	modport source (output valid, output status, output payload_length,
		output payload_offset, input ready);
	modport sink (input valid, input status, input payload_length,
		input payload_offset, output ready);
endinterface

FILE: rtl/core/nshc_step.sv
// Per-byte parser step: next state and optional result for one item.
// Depends on nshc_pkg.
module nshc_step import nshc_pkg::*; #(
	parameter int unsigned HEADER_WINDOW = HeaderWindowDef
) (
	input  state_t      st,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic [31:0] buffer_length,
	output state_t      st_nxt,
	output logic        res_valid,
	output result_t     res
);

	localparam logic [31:0] WinLimit = 32'(HEADER_WINDOW);

	state_t      cur;
	logic [31:0] limit;
	logic        is_colon;
	logic        is_digit;
	logic [3:0]  digit;
	logic [67:0] acc_x10;
	logic        ovf_step;
	logic [5:0]  pos;
	logic [64:0] frame_end;
	logic        frame_fits;
	logic [31:0] acc_sat;
	logic [31:0] idx_inc;
	logic [32:0] hdr_next;
	logic        hdr_last;

	always_comb begin
		cur = st;
		if (frame_start) begin
			cur = '0;
			cur.phase = PH_HEADER;
			cur.latched_buffer_length = buffer_length;
		end

		limit    = (cur.latched_buffer_length < WinLimit) ? cur.latched_buffer_length : WinLimit;
		is_colon = (data_byte == ChColon);
		is_digit = (data_byte >= Ch0) && (data_byte <= Ch9);
		digit    = 4'(data_byte - Ch0);
		// accum * 10 + digit, kept wide so a carry past 64 bits shows
		acc_x10  = {1'b0, cur.length_accum, 3'b000} + {3'b000, cur.length_accum, 1'b0}
			+ {64'd0, digit};
		ovf_step = |acc_x10[67:64];

		pos        = cur.byte_index[5:0];
		frame_end  = {1'b0, cur.length_accum} + 65'(pos) + 65'd2;
		frame_fits = (frame_end <= {33'd0, cur.latched_buffer_length});
		acc_sat    = (|cur.length_accum[63:32]) ? '1 : cur.length_accum[31:0];
		idx_inc    = cur.byte_index + 32'd1;
		hdr_next   = {1'b0, cur.byte_index} + 33'd1;
		hdr_last   = (hdr_next >= {1'b0, limit});

		st_nxt    = cur;
		res_valid = 1'b0;
		res       = '0;

		if (frame_start && (buffer_length < MinFrame)) begin
			res_valid    = 1'b1;
			res.status   = ST_SHORT;
			st_nxt.phase = PH_IDLE;
		end else begin
			unique case (cur.phase)
				PH_HEADER: begin
					if (is_colon) begin
						st_nxt.colon_position = pos;
						if (cur.bad_digit_seen) begin
							res_valid  = 1'b1;
							res.status = ST_BADDIGIT;
						end else if (pos == 6'd0) begin
							res_valid  = 1'b1;
							res.status = ST_EMPTY;
						end else if (cur.overflow_seen) begin
							res_valid          = 1'b1;
							res.status         = ST_OVERFLOW;
							res.payload_length = '1;
						end else if (!frame_fits) begin
							res_valid          = 1'b1;
							res.status         = ST_EXCEEDS;
							res.payload_length = acc_sat;
						end else begin
							// fits, so the length is below 2^32
							st_nxt.comma_position = 32'(pos) + 32'd1 + cur.length_accum[31:0];
							st_nxt.phase          = PH_PAYLOAD;
						end
						if (res_valid) begin
							st_nxt.phase = PH_IDLE;
						end
					end else begin
						if (is_digit) begin
							if (!cur.overflow_seen) begin
								if (ovf_step) begin
									st_nxt.overflow_seen = 1'b1;
								end else begin
									st_nxt.length_accum = acc_x10[63:0];
								end
							end
						end else begin
							st_nxt.bad_digit_seen = 1'b1;
						end
						if (hdr_last) begin
							res_valid    = 1'b1;
							res.status   = ST_NOCOLON;
							st_nxt.phase = PH_IDLE;
						end else begin
							st_nxt.byte_index = idx_inc;
						end
					end
				end
				PH_PAYLOAD: begin
					st_nxt.byte_index = idx_inc;
					if (idx_inc == cur.comma_position) begin
						res_valid          = 1'b1;
						res.payload_length = acc_sat;
						st_nxt.phase       = PH_IDLE;
						if (data_byte == ChComma) begin
							res.status         = ST_OK;
							res.payload_offset = cur.colon_position + 6'd1;
						end else begin
							res.status = ST_NOCOMMA;
						end
					end
				end
				PH_IDLE: ;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/netstring_header_checker.sv
// Netstring header checker, top level. Depends on nshc_pkg, nshc_in_if, nshc_out_if, nshc_step.
// Result path: a result becomes valid once the item that completes its frame has been accepted
// into the input register and has made one pass of the parser step into the result register.
// Throughput: 1 item per cycle; the input register stalls only while a result waits unread.
// Reset: arst_n clears the parse state to idle and drops any held item or result.
module netstring_header_checker import nshc_pkg::*; #(
	parameter int unsigned HEADER_WINDOW = HeaderWindowDef
) (
	input  logic       clk,
	input  logic       arst_n,
	nshc_in_if.sink    stream,
	nshc_out_if.source result
);

	// input register
	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        frame_start_s1;
	logic [31:0] buffer_length_s1;

	// parse state and result register
	state_t  st_q;
	logic    out_valid_q;
	result_t out_q;

	state_t  st_nxt;
	logic    res_valid;
	result_t res;
	logic    adv;

	// The held item is parsed once the result slot is free or being emptied.
	// Items with no result stall too when the slot is full; that keeps it simple.
	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_byte_s1     <= stream.data_byte;
			frame_start_s1   <= stream.frame_start;
			buffer_length_s1 <= stream.buffer_length;
		end
	end

	nshc_step #(
		.HEADER_WINDOW(HEADER_WINDOW)
	) u_step (
		.st           (st_q),
		.data_byte    (data_byte_s1),
		.frame_start  (frame_start_s1),
		.buffer_length(buffer_length_s1),
		.st_nxt       (st_nxt),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// all-zero state is idle
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= st_nxt;
			end
			// slot refills when the step yields a result, else empties on a take
			if (adv && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_q.status;
	assign result.payload_length = out_q.payload_length;
	assign result.payload_offset = out_q.payload_offset;

endmodule

FILE: rtl/core/nshc_checker.sv
// Port-level checks for the netstring header checker, bound to the top level.
// Depends on nshc_pkg and netstring_header_checker_defines.svh.
`include "netstring_header_checker_defines.svh"

module nshc_checker import nshc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [31:0] payload_length,
	input logic [5:0]  payload_offset
);

	// a stalled result keeps its value
	`NSHC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({status, payload_length, payload_offset}))

	// only a good frame reports an offset
	`NSHC_ASSERT_IMPLY(a_offset_ok_only, clk, arst_n, out_valid && (status != ST_OK), payload_offset == 6'd0)

	// short, no-colon, bad-digit and empty verdicts carry no length
	`NSHC_ASSERT_IMPLY(a_len_zero, clk, arst_n, out_valid && (status == ST_SHORT || status == ST_NOCOLON || status == ST_BADDIGIT || status == ST_EMPTY), payload_length == 32'd0)

	// overflow reports a saturated length
	`NSHC_ASSERT_IMPLY(a_len_sat, clk, arst_n, out_valid && (status == ST_OVERFLOW), payload_length == '1)

endmodule

bind netstring_header_checker nshc_checker u_nshc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.status        (result.status),
	.payload_length(result.payload_length),
	.payload_offset(result.payload_offset)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for netstring_header_checker: drives netstring bytes on the input channel and
// checks each frame verdict against a cycle-free parser written here. Depends on nshc_pkg,
// nshc_in_if and nshc_out_if from the RTL.
module testbench;
	import nshc_pkg::*;

	localparam int unsigned WINDOW = HeaderWindowDef;
	localparam int RESULT_LATENCY = 1;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TOTAL_ITEMS = 1050;

	typedef logic [7:0] byte_q_t[$];

	// Parser state mirroring the block's own; widths match it but for comma_at, kept 64 bits wide.
	typedef struct {
		logic [1:0]  phase;
		logic [31:0] byte_idx;
		logic [63:0] accum;
		bit          ovf;
		bit          bad;
		logic [31:0] buf_len;
		logic [63:0] comma_at;
		logic [5:0]  colon_at;
	} parse_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nshc_in_if  in_ch ();
	nshc_out_if out_ch ();

	netstring_header_checker #(
		.HEADER_WINDOW(WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(in_ch),
		.result(out_ch)
	);

	parse_state_t shadow;
	result_t      frame_verdicts_q[$];
	int           error_count = 0;
	int           sent_items = 0;    // items accepted by the block
	bit           no_gaps = 1'b0;    // set for back-to-back stretches on both sides
	int           stall_left = 0;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shared helpers
	// ------------------------------------------------------------------

	task automatic flag_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Mostly short gaps, a few long ones; none while no_gaps is set.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps) return 0;
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Every verdict closes the frame and drops back to idle.
	task automatic close_frame(input logic [2:0] st, input logic [31:0] len,
			input logic [5:0] off);
		result_t r;
		r.status = st;
		r.payload_length = len;
		r.payload_offset = off;
		frame_verdicts_q.push_back(r);
		shadow.phase = PH_IDLE;
	endtask

	// Header byte: colon search inside min(buffer length, window), digit accumulation.
	task automatic parse_header_byte(input logic [7:0] b);
		logic [63:0] limit;
		logic [63:0] need;
		logic [63:0] room;
		logic [63:0] d;
		limit = (shadow.buf_len > WINDOW) ? 64'(WINDOW) : {32'd0, shadow.buf_len};
		if (b == ChColon) begin
			shadow.colon_at = shadow.byte_idx[5:0];
			need = {58'd0, shadow.colon_at} + 64'd2;
			room = {32'd0, shadow.buf_len};
			// priority at the colon: bad digit, empty, overflow, fit
			if (shadow.bad)
				close_frame(ST_BADDIGIT, 32'd0, 6'd0);
			else if (shadow.colon_at == 6'd0)
				close_frame(ST_EMPTY, 32'd0, 6'd0);
			else if (shadow.ovf)
				close_frame(ST_OVERFLOW, 32'hFFFF_FFFF, 6'd0);
			else if (need > room || shadow.accum > room - need)
				close_frame(ST_EXCEEDS, sat32(shadow.accum), 6'd0);
			else begin
				shadow.comma_at = {58'd0, shadow.colon_at} + 64'd1 + shadow.accum;
				shadow.phase = PH_PAYLOAD;
			end
		end else begin
			if (b >= Ch0 && b <= Ch9) begin
				d = {56'd0, b - Ch0};
				if (!shadow.ovf) begin
					if (shadow.accum > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
						shadow.ovf = 1'b1;
					else
						shadow.accum = shadow.accum * 64'd10 + d;
				end
			end else begin
				shadow.bad = 1'b1;
			end
			if ({32'd0, shadow.byte_idx} + 64'd1 >= limit)
				close_frame(ST_NOCOLON, 32'd0, 6'd0);
			else
				shadow.byte_idx++;
		end
	endtask

	// Predicts the verdict (if any) caused by one accepted byte.
	task automatic parse_netstring_byte(input logic [7:0] b, input logic fs,
			input logic [31:0] blen);
		if (fs) begin
			// frame start drops whatever was in flight
			shadow = '{phase: PH_HEADER, byte_idx: 32'd0, accum: 64'd0, ovf: 1'b0,
				bad: 1'b0, buf_len: blen, comma_at: 64'd0, colon_at: 6'd0};
			if (blen < MinFrame)
				close_frame(ST_SHORT, 32'd0, 6'd0);
			else
				parse_header_byte(b);
		end else if (shadow.phase == PH_HEADER) begin
			parse_header_byte(b);
		end else if (shadow.phase == PH_PAYLOAD) begin
			shadow.byte_idx++;
			if ({32'd0, shadow.byte_idx} == shadow.comma_at) begin
				if (b == ChComma)
					close_frame(ST_OK, sat32(shadow.accum), 6'(shadow.colon_at + 6'd1));
				else
					close_frame(ST_NOCOMMA, sat32(shadow.accum), 6'd0);
			end
		end
	endtask

	// One item on the input channel: random gap, then hold until accepted.
	task automatic send_byte(input logic [7:0] b, input logic fs, input logic [31:0] blen);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= 8'($urandom);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.frame_start <= fs;
		in_ch.buffer_length <= blen;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent_items++;
		parse_netstring_byte(b, fs, blen);
	endtask

	// First byte carries the frame start; all bytes carry the same buffer length.
	task automatic send_frame(input byte_q_t q, input logic [31:0] blen);
		foreach (q[i])
			send_byte(q[i], i == 0, blen);
	endtask

	task automatic push_text(ref byte_q_t q, input string t);
		for (int i = 0; i < t.len(); i++)
			q.push_back(t[i]);
	endtask

	task automatic send_text(input string t, input logic [31:0] blen);
		byte_q_t q;
		push_text(q, t);
		send_frame(q, blen);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls on ready, and the verdict checker
	// ------------------------------------------------------------------

	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (frame_verdicts_q.size() == 0) begin
				flag_error($sformatf("unexpected result status=%0d len=%0d off=%0d",
					out_ch.status, out_ch.payload_length, out_ch.payload_offset));
			end else begin
				want = frame_verdicts_q.pop_front();
				if (out_ch.status !== want.status)
					flag_error($sformatf("status got %0d want %0d",
						out_ch.status, want.status));
				if (out_ch.payload_length !== want.payload_length)
					flag_error($sformatf("payload_length got %0d want %0d",
						out_ch.payload_length, want.payload_length));
				if (out_ch.payload_offset !== want.payload_offset)
					flag_error($sformatf("payload_offset got %0d want %0d",
						out_ch.payload_offset, want.payload_offset));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Buffer lengths 0..2 answer "short" on the start byte itself.
	task automatic test_short_buffers();
		send_text("7", 32'd0);
		send_text("1:", 32'd1);
		send_text("0:,", 32'd2);
	endtask

	// Header faults and their priority at the colon.
	task automatic test_header_errors();
		byte_q_t q;
		send_text("1/:a,", 32'd5);                   // just below '0'
		send_text("1;:a,", 32'd5);                   // two above '9'
		q = {};
		q.push_back(8'h31);
		q.push_back(8'h00);                          // NUL before colon is a bad digit
		push_text(q, ":a,");
		send_frame(q, 32'd5);
		send_text(":,", 32'd10);                     // empty length
		send_text("9999999999999999999999999x:", 32'd100);  // bad digit wins over overflow
		send_text("18446744073709551616:", 32'd100);        // one past 64 bits
		send_text("18446744073709551615:", 32'd100);        // 64-bit max, too big for buffer
		send_text("123", 32'd3);                     // window ends at buffer length
		q = {};
		repeat (WINDOW) q.push_back(Ch0);
		push_text(q, ":x,");                         // bytes past the window are ignored
		send_frame(q, 32'd1000);
	endtask

	// Exact fit test and the widest legal colon position.
	task automatic test_fit_boundary();
		byte_q_t q;
		send_text("3:abc,", 32'd6);
		send_text("3:abc,", 32'd5);
		send_text("0:,", 32'd3);
		send_text("12:", 32'd3);
		send_text("4294967293:", 32'hFFFF_FFFF);
		q = {};
		repeat (WINDOW - 2) q.push_back(Ch0);
		push_text(q, "3:abc,");                      // colon on the last window byte
		send_frame(q, 32'(WINDOW + 4));
		send_frame(q, 32'(WINDOW + 3));
	endtask

	task automatic test_comma_check();
		send_text("2:ab.", 32'd5);
		send_text("2:,a;", 32'd5);
		send_text("2:ab,zz", 32'd7);                 // trailing bytes after the verdict
	endtask

	// Idle bytes, restarts in the header and in the payload, back to back on both sides.
	task automatic test_restart_and_idle();
		no_gaps = 1'b1;
		repeat (3) send_byte(8'($urandom), 1'b0, $urandom);
		send_text("12", 32'd20);
		send_text("4294967283:ab", 32'hFFFF_FFFF);
		send_text("5:ab", 32'd8);
		send_text("1:a,", 32'd4);
		no_gaps = 1'b0;
	endtask

	// Mostly well-formed frames with random payloads, plus broken ones and noise.
	task automatic random_frame();
		byte_q_t q;
		logic [63:0] len;
		logic [31:0] blen;
		logic [7:0] x;
		int plen, kind, r, n, colon_idx;
		r = $urandom_range(0, 99);
		plen = (r < 80) ? $urandom_range(0, 12) :
			(r < 97) ? $urandom_range(13, 60) : $urandom_range(61, 200);
		len = plen;
		kind = $urandom_range(0, 99);
		no_gaps = ($urandom_range(0, 9) == 0);
		q = {};
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) q.push_back(Ch0);
		if (kind >= 73 && kind < 78) begin
			// huge length: random 64-bit value or a run of 19 to 26 random digits
			if ($urandom_range(0, 1))
				push_text(q, $sformatf("%0d", {$urandom, $urandom}));
			else
				repeat ($urandom_range(19, 26)) q.push_back(Ch0 + 8'($urandom_range(0, 9)));
			plen = $urandom_range(0, 3);
		end else begin
			push_text(q, $sformatf("%0d", len));
		end
		colon_idx = q.size();
		q.push_back(ChColon);
		repeat (plen) q.push_back(8'($urandom));
		q.push_back(ChComma);
		blen = q.size() + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5));

		if (kind >= 55 && kind < 62) begin
			do x = 8'($urandom); while (x == ChComma);
			q[q.size() - 1] = x;
		end else if (kind >= 62 && kind < 68) begin
			q[$urandom_range(0, colon_idx)] = 8'($urandom);
		end else if (kind >= 68 && kind < 73) begin
			blen = q.size() - $urandom_range(1, 3);
		end else if (kind >= 73 && kind < 78) begin
			blen = $urandom;
		end else if (kind >= 78 && kind < 83) begin
			q = {};
			n = $urandom_range(1, 40);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					do x = 8'($urandom); while (x == ChColon);
					q.push_back(x);
				end else begin
					q.push_back(Ch0 + 8'($urandom_range(0, 9)));
				end
			end
			blen = $urandom_range(3, 50);
		end else if (kind >= 83 && kind < 88) begin
			q = q[0:$urandom_range(0, q.size() - 1)];
		end else if (kind >= 88 && kind < 92) begin
			q = {};
			q.push_back(ChColon);
			repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
		end else if (kind >= 92 && kind < 96) begin
			blen = $urandom;
			repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
		end else if (kind >= 96) begin
			q = {};
			repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
			blen = $urandom_range(0, 2);
		end
		send_frame(q, blen);
		// stray bytes without frame start: ignored when idle, parsed as header or payload bytes otherwise
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, $urandom);
	endtask

	// Random frames until the whole run has sent about TOTAL_ITEMS items.
	task automatic test_random_frames();
		while (sent_items < TOTAL_ITEMS)
			random_frame();
		no_gaps = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		int waited;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'd0;
		in_ch.frame_start = 1'b0;
		in_ch.buffer_length = 32'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_short_buffers();
		test_header_errors();
		test_fit_boundary();
		test_comma_check();
		test_restart_and_idle();
		test_random_frames();

		@(negedge clk);
		in_ch.valid <= 1'b0;
		waited = 0;
		while (frame_verdicts_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (RESULT_LATENCY + 10) @(posedge clk);
		if (frame_verdicts_q.size() != 0)
			flag_error($sformatf("%0d expected results never arrived",
				frame_verdicts_q.size()));

		if (error_count == 0)
			$display("** netstring_header_checker: PASSED **");
		else
			$display("** netstring_header_checker: FAILED **");
		$finish;
	end

	// Watchdog: reports failure and ends the run if the main sequence hangs.
	initial begin
		#5_000_000;
		$display("** netstring_header_checker: FAILED **");
		$finish;
	end

endmodule

FILE: netstring_header_checker.f
+incdir+rtl/core
rtl/core/nshc_pkg.sv
rtl/core/nshc_in_if.sv
rtl/core/nshc_out_if.sv
rtl/core/nshc_step.sv
rtl/core/netstring_header_checker.sv
rtl/core/nshc_checker.sv
test/testbench.sv
